// ===== hw/rtl/mtu_probe_binary_search_core_defines.svh =====
// assertion macros for the path mtu prober
// used by mtu_probe_binary_search_core, expects clk_i and rst_ni in scope
`ifndef MTU_PROBE_BINARY_SEARCH_CORE_DEFINES_SVH
`define MTU_PROBE_BINARY_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define MTUPBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTUPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mtupbs_pkg.sv =====
// shared types, codes and helpers of the path mtu prober
// no dependencies
package mtupbs_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic        send_ok;
    logic        reply_is_response;
    logic [15:0] reply_len;
    logic [31:0] reply_tag;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] size;
    logic [31:0] tag;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        wdata;
  } cfg_t;

  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_SEND  = 3'd1;
  localparam logic [2:0] KIND_REPLY = 3'd2;
  localparam logic [2:0] KIND_WAIT  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  localparam logic RES_PROBE = 1'b0;
  localparam logic RES_DONE  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_MAX_MTU  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IPV6     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROBE_ID = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRIES    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEADLINE = 3'd4;

  localparam logic [15:0] RST_MAX_MTU  = 16'd1500;
  localparam logic [3:0]  RST_TRIES    = 4'd6;
  localparam logic [7:0]  RST_DEADLINE = 8'd10;

  localparam logic [15:0] MIN_V4    = 16'd576;
  localparam logic [15:0] MIN_V6    = 16'd1280;
  localparam logic [3:0]  RETRY_SAT = 4'd15;

  // rounded-up midpoint
  function automatic logic [15:0] halve(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b} + 17'd1;
    return sum[16:1];
  endfunction

endpackage

// ===== hw/rtl/mtupbs_if.sv =====
// valid/ready channel interfaces of the path mtu prober
// depends on mtupbs_pkg
interface mtupbs_req_if;
  logic              valid;
  logic              ready;
  mtupbs_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtupbs_res_if;
  logic              valid;
  logic              ready;
  mtupbs_pkg::res_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtupbs_cfg_if;
  logic              valid;
  logic              ready;
  mtupbs_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mtu_probe_binary_search_core.sv =====
// path mtu prober: binary search over probe sizes, one request per cycle unless the result stage stalls
// a request is registered in the input stage, then its result is registered in the result register
// throughput: one request per cycle unless stalled, set by the state update stage
// the input stage stalls only while the result register holds an untaken result
// async active-low reset: search idle, bounds cleared, registers at their defaults
// depends on mtupbs_pkg, mtupbs_if.sv and mtu_probe_binary_search_core_defines.svh
`include "mtu_probe_binary_search_core_defines.svh"

module mtu_probe_binary_search_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  mtupbs_req_if.sink   req_i,
  mtupbs_cfg_if.sink   cfg_i,
  mtupbs_res_if.source res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_WAIT
  } phase_e;

  // configuration
  logic [15:0] max_mtu_q;
  logic        ipv6_q;
  logic [31:0] probe_id_q;
  logic [3:0]  max_tries_q;
  logic [7:0]  deadline_q;

  // input stage
  logic              in_vld_q;
  mtupbs_pkg::req_t  in_q;

  // search state
  phase_e      phase_q, phase_d;
  logic [15:0] lb_q, lb_d;
  logic [15:0] ub_q, ub_d;
  logic [15:0] cs_q, cs_d;
  logic [15:0] ls_q, ls_d;
  logic [3:0]  retry_q, retry_d;
  logic [7:0]  elapsed_q, elapsed_d;

  // result stage
  logic              res_vld_q;
  mtupbs_pkg::res_t  res_q;
  mtupbs_pkg::res_t  res_d;

  logic        advance;
  logic        fire;
  logic        emit;
  logic        res_kind;
  logic [15:0] res_size;
  logic [15:0] abs_min;
  logic [15:0] dec_size;
  logic [31:0] reply_expect;
  logic        reply_match;

  assign advance = !res_vld_q || res_o.ready;
  assign fire    = in_vld_q && advance;
  assign req_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  assign abs_min      = ipv6_q ? mtupbs_pkg::MIN_V6 : mtupbs_pkg::MIN_V4;
  assign dec_size     = cs_q - 16'd1;
  assign reply_expect = probe_id_q + {16'd0, in_q.reply_len};
  assign reply_match  = (phase_q == PH_WAIT) && in_q.reply_is_response &&
                        (in_q.reply_len <= ub_q) && (in_q.reply_tag == reply_expect);

  always_comb begin
    phase_d   = phase_q;
    lb_d      = lb_q;
    ub_d      = ub_q;
    cs_d      = cs_q;
    ls_d      = ls_q;
    retry_d   = retry_q;
    elapsed_d = elapsed_q;
    emit      = 1'b0;
    res_kind  = mtupbs_pkg::RES_PROBE;
    res_size  = 16'd0;
    unique case (in_q.kind)
      mtupbs_pkg::KIND_START: begin
        lb_d      = abs_min;
        ub_d      = max_mtu_q;
        cs_d      = max_mtu_q;
        ls_d      = max_mtu_q;
        retry_d   = 4'd0;
        elapsed_d = 8'd0;
        emit      = 1'b1;
        if (max_mtu_q <= abs_min) begin
          res_kind = mtupbs_pkg::RES_DONE;
        end else begin
          res_size = max_mtu_q;
        end
      end
      mtupbs_pkg::KIND_SEND: begin
        if (phase_q == PH_SEND) begin
          if (in_q.send_ok) begin
            if (ls_q == cs_q) begin
              if (retry_q < mtupbs_pkg::RETRY_SAT) begin
                retry_d = retry_q + 4'd1;
              end
            end else begin
              retry_d = 4'd0;
              ls_d    = cs_q;
            end
            phase_d = PH_WAIT;
          end else begin
            emit     = 1'b1;
            res_kind = mtupbs_pkg::RES_DONE;
            if (cs_q == ub_q && cs_q != 16'd0) begin
              cs_d = dec_size;
              ub_d = dec_size;
              if (dec_size >= abs_min) begin
                res_kind = mtupbs_pkg::RES_PROBE;
                res_size = dec_size;
              end
            end
          end
        end
      end
      mtupbs_pkg::KIND_REPLY: begin
        if (reply_match) begin
          retry_d = 4'd0;
          emit    = 1'b1;
          if (in_q.reply_len == ub_q) begin
            res_kind = mtupbs_pkg::RES_DONE;
            res_size = in_q.reply_len;
          end else if (in_q.reply_len > lb_q) begin
            lb_d     = in_q.reply_len;
            res_size = mtupbs_pkg::halve(in_q.reply_len,
                                         (in_q.reply_len >= ls_q) ? ub_q : ls_q);
            cs_d     = res_size;
          end else begin
            res_size = mtupbs_pkg::halve(lb_q, ls_q);
            cs_d     = res_size;
          end
        end
      end
      mtupbs_pkg::KIND_WAIT: begin
        if (phase_q == PH_WAIT) begin
          emit = 1'b1;
          if (retry_q >= max_tries_q) begin
            res_kind = mtupbs_pkg::RES_DONE;
            res_size = lb_q;
          end else begin
            res_size = mtupbs_pkg::halve(lb_q, ls_q);
            cs_d     = res_size;
          end
        end
      end
      mtupbs_pkg::KIND_TICK: begin
        if (phase_q == PH_SEND || phase_q == PH_WAIT) begin
          if (elapsed_q >= deadline_q) begin
            emit     = 1'b1;
            res_kind = mtupbs_pkg::RES_DONE;
            res_size = (lb_q == abs_min) ? 16'd0 : lb_q;
          end else begin
            elapsed_d = elapsed_q + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      phase_d = (res_kind == mtupbs_pkg::RES_DONE) ? PH_IDLE : PH_SEND;
    end
    res_d.result_kind = res_kind;
    res_d.size        = res_size;
    res_d.tag         = (res_kind == mtupbs_pkg::RES_DONE) ? 32'd0
                                                           : probe_id_q + {16'd0, res_size};
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_mtu_q   <= mtupbs_pkg::RST_MAX_MTU;
      ipv6_q      <= 1'b0;
      probe_id_q  <= 32'd0;
      max_tries_q <= mtupbs_pkg::RST_TRIES;
      deadline_q  <= mtupbs_pkg::RST_DEADLINE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        mtupbs_pkg::CFG_MAX_MTU:  max_mtu_q   <= cfg_i.data.wdata[15:0];
        mtupbs_pkg::CFG_IPV6:     ipv6_q      <= cfg_i.data.wdata[0];
        mtupbs_pkg::CFG_PROBE_ID: probe_id_q  <= cfg_i.data.wdata;
        mtupbs_pkg::CFG_TRIES:    max_tries_q <= cfg_i.data.wdata[3:0];
        mtupbs_pkg::CFG_DEADLINE: deadline_q  <= cfg_i.data.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.data;
    end
  end

  // search state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      lb_q      <= 16'd0;
      ub_q      <= 16'd0;
      cs_q      <= 16'd0;
      ls_q      <= 16'd0;
      retry_q   <= 4'd0;
      elapsed_q <= 8'd0;
      res_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q   <= phase_d;
        lb_q      <= lb_d;
        ub_q      <= ub_d;
        cs_q      <= cs_d;
        ls_q      <= ls_d;
        retry_q   <= retry_d;
        elapsed_q <= elapsed_d;
      end
      if (advance) begin
        res_vld_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  `MTUPBS_ASSERT_IMPL(a_done_tag_zero, res_vld_q && res_q.result_kind == mtupbs_pkg::RES_DONE, res_q.tag == 32'd0, "finished result with nonzero tag")
  `MTUPBS_ASSERT_NEXT(a_probe_enters_send, fire && emit && res_kind == mtupbs_pkg::RES_PROBE, phase_q == PH_SEND, "probe issued but not awaiting send result")
  `MTUPBS_ASSERT_NEXT(a_done_goes_idle, fire && emit && res_kind == mtupbs_pkg::RES_DONE, phase_q == PH_IDLE && res_vld_q, "finished search not idle")

endmodule
